// ----- rtl/voxel_surface_edge_map_assert.svh -----
`ifndef VOXEL_SURFACE_EDGE_MAP_ASSERT_SVH
`define VOXEL_SURFACE_EDGE_MAP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VSEM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VSEM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vsem_pkg.sv -----
`default_nettype none

package vsem_pkg;

    localparam int MAX_SIZE_X = 256;
    localparam int MAX_SIZE_Y = 256;

    // Register field widths
    localparam int SIZE_XW = 9;
    localparam int SIZE_YW = 9;
    localparam int SIZE_ZW = 16;
    localparam int CFG_DW  = 16;
    localparam int CFG_IW  = 2;

    localparam int VOXW = 8;

    // Effective sizes and raster positions
    localparam int EXW = $clog2(MAX_SIZE_X + 1);
    localparam int EYW = $clog2(MAX_SIZE_Y + 1);
    localparam int XW  = $clog2(MAX_SIZE_X);
    localparam int YW  = $clog2(MAX_SIZE_Y);
    localparam int ZW  = SIZE_ZW;

    localparam int PLANE_MAX = MAX_SIZE_X * MAX_SIZE_Y;
    localparam int PLW       = $clog2(PLANE_MAX + 1);
    localparam int LAG_MAX   = PLANE_MAX + MAX_SIZE_X + 1;
    localparam int PW        = $clog2(LAG_MAX + 2);

    // History ring: two planes plus one row plus two voxels
    localparam int RING_LEN = 2 * PLANE_MAX + MAX_SIZE_X + 2;
    localparam int AW       = $clog2(RING_LEN);

    // Cells: center, x pair, y pair, z pair
    localparam int NCELL = 4;

    localparam int FIFO_DEPTH = 8;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);

    localparam logic [VOXW-1:0] SET_LEVEL = 8'd255;
    localparam logic [VOXW-1:0] EDGE_ON   = 8'd255;
    localparam logic [VOXW-1:0] EDGE_OFF  = 8'd0;

    localparam logic OPC_VOXEL = 1'b0;
    localparam logic OPC_FLUSH = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } vsem_reg_t;

    // What travels from cell to cell: one result request plus one ring write
    typedef struct packed {
        logic             emit;
        logic             last;
        logic             self_bit;
        logic             interior;
        logic [NCELL-1:0] lo_ok;
        logic [NCELL-1:0] hi_ok;
        logic [AW-1:0]    center;
        logic             wr_en;
        logic [AW-1:0]    wr_addr;
        logic             wr_bit;
    } vsem_tok_t;

    typedef struct packed {
        logic [EXW-1:0] ex;
        logic [PLW-1:0] plane;
    } vsem_geom_t;

endpackage

`default_nettype wire

// ----- rtl/vsem_cell.sv -----
`default_nettype none

module vsem_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [vsem_pkg::PLW-1:0]  reach,
    input  logic                      capture_self,
    input  vsem_pkg::vsem_tok_t       tok_in,
    output vsem_pkg::vsem_tok_t       tok_out
);

    logic                    mem [vsem_pkg::RING_LEN];
    vsem_pkg::vsem_tok_t     tok_reg;
    logic                    rd_lo_reg;
    logic                    rd_hi_reg;
    logic [vsem_pkg::AW:0]   c_ext;
    logic [vsem_pkg::AW:0]   d_ext;
    logic [vsem_pkg::AW:0]   sum_hi;
    logic [vsem_pkg::AW:0]   sum_lo;
    logic [vsem_pkg::AW-1:0] lo_addr;
    logic [vsem_pkg::AW-1:0] hi_addr;

    // Ring addresses center - reach and center + reach, one wrap correction each
    always_comb
    begin
        c_ext  = {1'b0, tok_in.center};
        d_ext  = (vsem_pkg::AW + 1)'(reach);
        sum_hi = c_ext + d_ext;
        if (sum_hi >= (vsem_pkg::AW + 1)'(vsem_pkg::RING_LEN))
        begin
            sum_hi = sum_hi - (vsem_pkg::AW + 1)'(vsem_pkg::RING_LEN);
        end
        if (c_ext >= d_ext)
        begin
            sum_lo = c_ext - d_ext;
        end
        else
        begin
            sum_lo = c_ext + (vsem_pkg::AW + 1)'(vsem_pkg::RING_LEN) - d_ext;
        end
        lo_addr = sum_lo[vsem_pkg::AW-1:0];
        hi_addr = sum_hi[vsem_pkg::AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.wr_en)
        begin
            mem[tok_in.wr_addr] <= tok_in.wr_bit;
        end
        rd_lo_reg <= mem[lo_addr];
        rd_hi_reg <= mem[hi_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    // Fold this cell's pair into the running interior flag, retire its flags
    always_comb
    begin
        tok_out          = tok_reg;
        tok_out.self_bit = capture_self ? rd_lo_reg : tok_reg.self_bit;
        tok_out.interior = tok_reg.interior & tok_reg.lo_ok[0] & rd_lo_reg
                           & tok_reg.hi_ok[0] & rd_hi_reg;
        tok_out.lo_ok    = tok_reg.lo_ok >> 1;
        tok_out.hi_ok    = tok_reg.hi_ok >> 1;
    end

endmodule

`default_nettype wire

// ----- rtl/vsem_head.sv -----
`default_nettype none

module vsem_head (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_fire,
    input  logic                         in_opcode,
    input  logic [vsem_pkg::VOXW-1:0]    in_voxel,
    input  logic                         cfg_fire,
    input  logic [vsem_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [vsem_pkg::CFG_DW-1:0]  cfg_data,
    output vsem_pkg::vsem_tok_t          tok,
    output vsem_pkg::vsem_geom_t         geom,
    output logic                         emit_now
);

    logic [vsem_pkg::EXW-1:0] ex_reg,      ex_next;
    logic [vsem_pkg::EYW-1:0] ey_reg,      ey_next;
    logic [vsem_pkg::ZW-1:0]  ez_reg,      ez_next;
    logic [vsem_pkg::PLW-1:0] plane_reg,   plane_next;
    logic [vsem_pkg::PW-1:0]  lag_reg,     lag_next;
    logic [vsem_pkg::PW-1:0]  pending_reg, pending_next;
    logic [vsem_pkg::XW-1:0]  out_x_reg,   out_x_next;
    logic [vsem_pkg::YW-1:0]  out_y_reg,   out_y_next;
    logic [vsem_pkg::ZW-1:0]  out_z_reg,   out_z_next;
    logic [vsem_pkg::AW-1:0]  out_ptr_reg, out_ptr_next;
    logic [vsem_pkg::AW-1:0]  wr_ptr_reg,  wr_ptr_next;
    vsem_pkg::vsem_tok_t      tok_reg,     tok_next;

    logic                              is_voxel;
    logic [vsem_pkg::EXW-1:0]          ox1;
    logic [vsem_pkg::EYW-1:0]          oy1;
    logic [vsem_pkg::ZW:0]             oz1;
    logic                              x_hi, y_hi, z_hi;
    logic                              rcv_1, rcv_x, rcv_p;
    logic [vsem_pkg::EXW+vsem_pkg::EYW-1:0] prod;

    function automatic logic [vsem_pkg::EXW-1:0] clamp_x(
        input logic [vsem_pkg::SIZE_XW-1:0] v);
        logic [vsem_pkg::EXW-1:0] r;
        begin
            if (v == '0)
            begin
                r = vsem_pkg::EXW'(1);
            end
            else if (int'(v) > vsem_pkg::MAX_SIZE_X)
            begin
                r = vsem_pkg::EXW'(vsem_pkg::MAX_SIZE_X);
            end
            else
            begin
                r = vsem_pkg::EXW'(v);
            end
            return r;
        end
    endfunction

    function automatic logic [vsem_pkg::EYW-1:0] clamp_y(
        input logic [vsem_pkg::SIZE_YW-1:0] v);
        logic [vsem_pkg::EYW-1:0] r;
        begin
            if (v == '0)
            begin
                r = vsem_pkg::EYW'(1);
            end
            else if (int'(v) > vsem_pkg::MAX_SIZE_Y)
            begin
                r = vsem_pkg::EYW'(vsem_pkg::MAX_SIZE_Y);
            end
            else
            begin
                r = vsem_pkg::EYW'(v);
            end
            return r;
        end
    endfunction

    assign is_voxel = (in_opcode == vsem_pkg::OPC_VOXEL);
    assign emit_now = in_fire & (is_voxel ? (pending_reg >= lag_reg)
                                          : (pending_reg != '0));

    assign ox1 = vsem_pkg::EXW'(out_x_reg) + vsem_pkg::EXW'(1);
    assign oy1 = vsem_pkg::EYW'(out_y_reg) + vsem_pkg::EYW'(1);
    assign oz1 = {1'b0, out_z_reg} + (vsem_pkg::ZW + 1)'(1);

    assign x_hi = ox1 < ex_reg;
    assign y_hi = oy1 < ey_reg;
    assign z_hi = oz1 < {1'b0, ez_reg};

    // A forward neighbor exists only once it has arrived; a voxel-triggered
    // result always has all of them.
    assign rcv_1 = is_voxel | (pending_reg > vsem_pkg::PW'(1));
    assign rcv_x = is_voxel | (pending_reg > vsem_pkg::PW'(ex_reg));
    assign rcv_p = is_voxel | (pending_reg > vsem_pkg::PW'(plane_reg));

    always_comb
    begin
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        ez_next      = ez_reg;
        plane_next   = plane_reg;
        lag_next     = lag_reg;
        pending_next = pending_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_z_next   = out_z_reg;
        out_ptr_next = out_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        prod         = '0;

        tok_next          = '0;
        tok_next.emit     = emit_now;
        tok_next.last     = (ox1 == ex_reg) && (oy1 == ey_reg) && (oz1 == {1'b0, ez_reg});
        tok_next.self_bit = 1'b0;
        tok_next.interior = 1'b1;
        tok_next.lo_ok    = {out_z_reg != '0, out_y_reg != '0, out_x_reg != '0, 1'b1};
        tok_next.hi_ok    = {z_hi & rcv_p, y_hi & rcv_x, x_hi & rcv_1, 1'b1};
        tok_next.center   = out_ptr_reg;
        tok_next.wr_en    = in_fire & is_voxel;
        tok_next.wr_addr  = wr_ptr_reg;
        tok_next.wr_bit   = (in_voxel == vsem_pkg::SET_LEVEL);

        if (cfg_fire)
        begin
            unique case (cfg_index)
                vsem_pkg::REG_SIZE_X:
                begin
                    ex_next    = clamp_x(cfg_data[vsem_pkg::SIZE_XW-1:0]);
                    prod       = ex_next * ey_reg;
                    plane_next = vsem_pkg::PLW'(prod);
                end
                vsem_pkg::REG_SIZE_Y:
                begin
                    ey_next    = clamp_y(cfg_data[vsem_pkg::SIZE_YW-1:0]);
                    prod       = ex_reg * ey_next;
                    plane_next = vsem_pkg::PLW'(prod);
                end
                vsem_pkg::REG_SIZE_Z:
                begin
                    ez_next = (cfg_data[vsem_pkg::SIZE_ZW-1:0] == '0) ? vsem_pkg::ZW'(1)
                              : cfg_data[vsem_pkg::SIZE_ZW-1:0];
                end
                default:
                begin
                end
            endcase
            lag_next = vsem_pkg::PW'(plane_next) + vsem_pkg::PW'(ex_next) + vsem_pkg::PW'(1);
            if (cfg_index == vsem_pkg::REG_SIZE_X || cfg_index == vsem_pkg::REG_SIZE_Y
                || cfg_index == vsem_pkg::REG_SIZE_Z)
            begin
                pending_next = '0;
                out_x_next   = '0;
                out_y_next   = '0;
                out_z_next   = '0;
                out_ptr_next = wr_ptr_reg;
            end
            tok_next.emit  = 1'b0;
            tok_next.wr_en = 1'b0;
        end
        else if (in_fire)
        begin
            if (is_voxel)
            begin
                wr_ptr_next = (wr_ptr_reg == vsem_pkg::AW'(vsem_pkg::RING_LEN - 1))
                              ? '0 : wr_ptr_reg + vsem_pkg::AW'(1);
            end
            if (is_voxel && !emit_now)
            begin
                pending_next = pending_reg + vsem_pkg::PW'(1);
            end
            else if (!is_voxel && emit_now)
            begin
                pending_next = pending_reg - vsem_pkg::PW'(1);
            end
            if (emit_now)
            begin
                out_ptr_next = (out_ptr_reg == vsem_pkg::AW'(vsem_pkg::RING_LEN - 1))
                               ? '0 : out_ptr_reg + vsem_pkg::AW'(1);
                if (ox1 == ex_reg)
                begin
                    out_x_next = '0;
                    if (oy1 == ey_reg)
                    begin
                        out_y_next = '0;
                        out_z_next = (oz1 == {1'b0, ez_reg}) ? '0 : oz1[vsem_pkg::ZW-1:0];
                    end
                    else
                    begin
                        out_y_next = oy1[vsem_pkg::YW-1:0];
                    end
                end
                else
                begin
                    out_x_next = ox1[vsem_pkg::XW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_reg      <= vsem_pkg::EXW'(vsem_pkg::MAX_SIZE_X);
            ey_reg      <= vsem_pkg::EYW'(vsem_pkg::MAX_SIZE_Y);
            ez_reg      <= vsem_pkg::ZW'(1);
            plane_reg   <= vsem_pkg::PLW'(vsem_pkg::PLANE_MAX);
            lag_reg     <= vsem_pkg::PW'(vsem_pkg::LAG_MAX);
            pending_reg <= '0;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            out_z_reg   <= '0;
            out_ptr_reg <= '0;
            wr_ptr_reg  <= '0;
            tok_reg     <= '0;
        end
        else
        begin
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
            ez_reg      <= ez_next;
            plane_reg   <= plane_next;
            lag_reg     <= lag_next;
            pending_reg <= pending_next;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            out_z_reg   <= out_z_next;
            out_ptr_reg <= out_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok        = tok_reg;
    assign geom.ex    = ex_reg;
    assign geom.plane = plane_reg;

endmodule

`default_nettype wire

// ----- rtl/voxel_surface_edge_map.sv -----
// Throughput: one item (voxel or flush) per clock; input stalls while eight results wait
// downstream or while a register write is offered.
// Path: a releasing item's token passes the head register, each cell register and the output queue
// (a voxel releases the voxel one plane plus one row plus one voxel older; a flush, the oldest).
// Reset: sizes 256 x 256 x 1, stream positions and result queue cleared; no clearing pass,
// so an item is accepted in the first cycle after reset.
`default_nettype none

module voxel_surface_edge_map (
    input  logic                          clk,
    input  logic                          rst_n,
    // Voxel stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] voxel_value
    input  logic                          s_axis_tuser,   // [0] opcode
    // Edge map out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] edge_value
    output logic                          m_axis_tlast,
    // Register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vsem_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [vsem_pkg::CFG_DW-1:0]   cfg_data
);

    logic                     in_fire;
    logic                     m_fire;
    logic                     cfg_fire;
    logic                     emit_now;
    vsem_pkg::vsem_geom_t     geom;
    vsem_pkg::vsem_tok_t      tok_chain [vsem_pkg::NCELL+1];
    logic [vsem_pkg::PLW-1:0] cell_dist [vsem_pkg::NCELL];
    vsem_pkg::vsem_tok_t      tail;
    logic                     tail_edge;

    // Results issued by the head but not yet taken downstream
    logic [vsem_pkg::FCW-1:0] out_cnt_reg,   out_cnt_next;
    logic [1:0]               ofifo_mem [vsem_pkg::FIFO_DEPTH];
    logic [vsem_pkg::FAW-1:0] ofifo_wr_reg,  ofifo_rd_reg;
    logic [vsem_pkg::FCW-1:0] ofifo_cnt_reg, ofifo_cnt_next;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_fire   = s_axis_tvalid & s_axis_tready;
    assign m_fire    = m_axis_tvalid & m_axis_tready;

    // Take a new item only while every result in flight has a queue slot waiting
    // and no register write is offered.
    assign s_axis_tready = !cfg_valid && (out_cnt_reg < vsem_pkg::FCW'(vsem_pkg::FIFO_DEPTH));

    // Head: raster positions, pending count, ring pointers; issues one token per item.
    vsem_head u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_opcode (s_axis_tuser),
        .in_voxel  (s_axis_tdata),
        .cfg_fire  (cfg_fire),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tok       (tok_chain[0]),
        .geom      (geom),
        .emit_now  (emit_now)
    );

    // Cell distances: center, x neighbors, y neighbors, z neighbors.
    assign cell_dist[0] = '0;
    assign cell_dist[1] = vsem_pkg::PLW'(1);
    assign cell_dist[2] = vsem_pkg::PLW'(geom.ex);
    assign cell_dist[3] = geom.plane;

    // Chain: each cell keeps its own copy of the history ring, reads the voxel pair
    // at its distance around the center, folds it in and hands the token on.
    // Ring writes ride the same tokens, so every copy sees the same order.
    for (genvar g = 0; g < vsem_pkg::NCELL; g++)
    begin : g_cell
        vsem_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .reach        (cell_dist[g]),
            .capture_self (1'(g == 0)),
            .tok_in       (tok_chain[g]),
            .tok_out      (tok_chain[g+1])
        );
    end

    assign tail      = tok_chain[vsem_pkg::NCELL];
    assign tail_edge = tail.self_bit & ~tail.interior;

    // Output queue: decouple the chain from result-side stalls.
    always_ff @(posedge clk)
    begin
        if (tail.emit)
        begin
            ofifo_mem[ofifo_wr_reg] <= {tail.last, tail_edge};
        end
    end

    always_comb
    begin
        ofifo_cnt_next = ofifo_cnt_reg;
        if (tail.emit && !m_fire)
        begin
            ofifo_cnt_next = ofifo_cnt_reg + vsem_pkg::FCW'(1);
        end
        else if (!tail.emit && m_fire)
        begin
            ofifo_cnt_next = ofifo_cnt_reg - vsem_pkg::FCW'(1);
        end

        out_cnt_next = out_cnt_reg;
        if (emit_now && !m_fire)
        begin
            out_cnt_next = out_cnt_reg + vsem_pkg::FCW'(1);
        end
        else if (!emit_now && m_fire)
        begin
            out_cnt_next = out_cnt_reg - vsem_pkg::FCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofifo_wr_reg  <= '0;
            ofifo_rd_reg  <= '0;
            ofifo_cnt_reg <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            if (tail.emit)
            begin
                ofifo_wr_reg <= ofifo_wr_reg + vsem_pkg::FAW'(1);
            end
            if (m_fire)
            begin
                ofifo_rd_reg <= ofifo_rd_reg + vsem_pkg::FAW'(1);
            end
            ofifo_cnt_reg <= ofifo_cnt_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    // Drive the result transaction from the queue head.
    assign m_axis_tvalid = ofifo_cnt_reg != '0;
    assign m_axis_tdata  = ofifo_mem[ofifo_rd_reg][0] ? vsem_pkg::EDGE_ON : vsem_pkg::EDGE_OFF;
    assign m_axis_tlast  = ofifo_mem[ofifo_rd_reg][1];

`include "voxel_surface_edge_map_assert.svh"

    `VSEM_ASSERT_IMP(a_ofifo_room, tail.emit,
        ofifo_cnt_reg < vsem_pkg::FCW'(vsem_pkg::FIFO_DEPTH), "result queue overflow")
    `VSEM_ASSERT_IMP(a_credit_cover, 1'b1, out_cnt_reg >= ofifo_cnt_reg,
        "queued results exceed issued results")
    `VSEM_ASSERT_IMP(a_tail_credit, tail.emit, out_cnt_reg > ofifo_cnt_reg,
        "chain delivered a result that was never issued")
    `VSEM_ASSERT_NXT(a_tail_lands, tail.emit, ofifo_cnt_reg != '0,
        "result from chain not queued")

endmodule

`default_nettype wire

// ----- tb/sv/voxel_surface_edge_map_tb.sv -----
`timescale 1ns / 100ps

module voxel_surface_edge_map_tb;

    // History ring of the predictor: two planes plus one row plus two voxels at full size
    localparam int RING_DEPTH  = 2 * vsem_pkg::MAX_SIZE_X * vsem_pkg::MAX_SIZE_Y
                                 + vsem_pkg::MAX_SIZE_X + 2;
    localparam int SETTLE      = 12;
    localparam int ITEM_TARGET = 700;    // input transactions before the stimulus stops

    // Index 3 exists on the port but names no register
    localparam logic [vsem_pkg::CFG_IW-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [vsem_pkg::VOXW-1:0] edge_value;
        logic                      last;
    } surface_t;

    // Tracks the stream exactly as the block sees it and keeps the queue of
    // surface results still owed by the block.
    class edge_map_scoreboard;
        bit          ring [RING_DEPTH];
        int unsigned wr_ptr;
        logic [8:0]  reg_x;
        logic [8:0]  reg_y;
        logic [15:0] reg_z;
        int unsigned in_x, in_y, in_z;
        int unsigned out_x, out_y, out_z;
        int unsigned unanswered;
        surface_t    edge_expected [$];
        int          faults;

        function new();
            reg_x  = 9'd256;
            reg_y  = 9'd256;
            reg_z  = 16'd1;
            wr_ptr = 0;
            faults = 0;
            restart();
        endfunction

        function void restart();
            in_x = 0; in_y = 0; in_z = 0;
            out_x = 0; out_y = 0; out_z = 0;
            unanswered = 0;
        endfunction

        // Zero acts as one, anything above the cap acts as the cap
        function int unsigned span(logic [15:0] raw, int unsigned cap);
            if (raw == 0)
                return 1;
            if (raw > cap)
                return cap;
            return 32'(raw);
        endfunction

        function int unsigned dim_x();
            return span(16'(reg_x), vsem_pkg::MAX_SIZE_X);
        endfunction

        function int unsigned dim_y();
            return span(16'(reg_y), vsem_pkg::MAX_SIZE_Y);
        endfunction

        function int unsigned dim_z();
            return span(reg_z, 65535);
        endfunction

        function void step_pos(inout int unsigned x, inout int unsigned y,
                               inout int unsigned z);
            x++;
            if (x >= dim_x())
            begin
                x = 0;
                y++;
                if (y >= dim_y())
                begin
                    y = 0;
                    z++;
                    if (z >= dim_z())
                        z = 0;
                end
            end
        endfunction

        // Bit of the voxel that lies back voxels behind the next write slot
        function bit ring_bit(longint back);
            longint idx;
            idx = (longint'(wr_ptr) + RING_DEPTH - (back % RING_DEPTH)) % RING_DEPTH;
            return ring[idx];
        endfunction

        // Neighbour at a linear offset from the oldest pending voxel; one not yet
        // received counts as unset
        function bit neighbor_set(longint off);
            longint back;
            back = longint'(unanswered) - off;
            if (back <= 0)
                return 1'b0;
            return ring_bit(back);
        endfunction

        function void release_oldest();
            surface_t    res;
            int unsigned sx, sy, sz;
            longint      plane;
            bit          self_set, interior;
            sx       = dim_x();
            sy       = dim_y();
            sz       = dim_z();
            plane    = longint'(sx) * longint'(sy);
            self_set = ring_bit(unanswered);
            interior = self_set
                && out_x > 0 && neighbor_set(-1)
                && out_x + 1 < sx && neighbor_set(1)
                && out_y > 0 && neighbor_set(-longint'(sx))
                && out_y + 1 < sy && neighbor_set(longint'(sx))
                && out_z > 0 && neighbor_set(-plane)
                && out_z + 1 < sz && neighbor_set(plane);
            res.edge_value = (self_set && !interior) ? vsem_pkg::EDGE_ON : vsem_pkg::EDGE_OFF;
            res.last       = (out_x + 1 == sx) && (out_y + 1 == sy) && (out_z + 1 == sz);
            edge_expected.push_back(res);
            step_pos(out_x, out_y, out_z);
            unanswered--;
        endfunction

        function void note_input(logic op, logic [vsem_pkg::VOXW-1:0] val);
            int unsigned lag;
            lag = dim_x() * dim_y() + dim_x() + 1;
            if (op == vsem_pkg::OPC_FLUSH)
            begin
                if (unanswered != 0)
                    release_oldest();
                return;
            end
            ring[wr_ptr] = (val == vsem_pkg::SET_LEVEL);
            wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
            step_pos(in_x, in_y, in_z);
            unanswered++;
            if (unanswered > lag)
                release_oldest();
        endfunction

        // Any real register write restarts the stream and drops what is pending
        function void write_reg(logic [vsem_pkg::CFG_IW-1:0] idx,
                                logic [vsem_pkg::CFG_DW-1:0] data);
            case (idx)
                vsem_pkg::REG_SIZE_X: reg_x = data[8:0];
                vsem_pkg::REG_SIZE_Y: reg_y = data[8:0];
                vsem_pkg::REG_SIZE_Z: reg_z = data[15:0];
                default:              return;
            endcase
            restart();
        endfunction

        function void check_result(logic [vsem_pkg::VOXW-1:0] value, logic last);
            surface_t want;
            if (edge_expected.size() == 0)
            begin
                $error("unexpected result: edge_value %0d, last %0d", value, last);
                faults++;
                return;
            end
            want = edge_expected.pop_front();
            if (value !== want.edge_value)
            begin
                $error("edge_value: expected %0d, got %0d", want.edge_value, value);
                faults++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, last);
                faults++;
            end
        endfunction
    endclass

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata  = 8'd0;
    logic                        s_axis_tuser  = vsem_pkg::OPC_VOXEL;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [7:0]                  m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [vsem_pkg::CFG_IW-1:0] cfg_index     = vsem_pkg::REG_SIZE_X;
    logic [vsem_pkg::CFG_DW-1:0] cfg_data      = '0;

    edge_map_scoreboard sb = new();
    int                 items_sent = 0;
    bit                 no_idle    = 1'b0;   // set for phases that run back to back
    int                 stall_left = 0;

    voxel_surface_edge_map u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 65)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(4, 24));
    endfunction

    // Set voxels at the chosen density; the rest are 0, 254 just below the level, or random
    function automatic logic [7:0] pick_voxel(int density);
        if ($urandom_range(0, 99) < density)
            return vsem_pkg::SET_LEVEL;
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    // Result side: stall at random, hold ready low for the chosen stretch
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left    <= pick_gap();
        end
    end

    // Check every result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // One input transaction; the predictor notes it at the accepting edge.
    // Valid stays high into the next item unless a gap is drawn.
    task automatic send_item(input logic op, input logic [7:0] val);
        int gap;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(op, val);
        items_sent++;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One register write transaction, then drop valid for a cycle
    task automatic set_reg(input logic [vsem_pkg::CFG_IW-1:0] idx,
                           input logic [vsem_pkg::CFG_DW-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every owed result is out, then let the pipe go quiet
    task automatic wait_results(input int extra);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.edge_expected.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    // Reconfigure while idle, stream voxels with optional flush noise, then drain
    // every pending voxel by flushes plus one flush that finds nothing left.
    task automatic run_phase(input logic [15:0] rx, input logic [15:0] ry,
                             input logic [15:0] rz, input int n, input int density,
                             input bit noise, input bit hold);
        int k;
        int drains;
        wait_results(SETTLE);
        no_idle = ($urandom_range(0, 3) == 0);
        set_reg(vsem_pkg::REG_SIZE_X, rx);
        set_reg(vsem_pkg::REG_SIZE_Y, ry);
        set_reg(vsem_pkg::REG_SIZE_Z, rz);
        if ($urandom_range(0, 3) == 0)
            set_reg(REG_UNUSED, 16'($urandom));
        for (k = 0; k < n; k++)
        begin
            if (hold && k == n / 2)
                wait_results(0);
            if (noise && $urandom_range(0, 9) == 0)
                send_item(vsem_pkg::OPC_FLUSH, 8'($urandom));
            send_item(vsem_pkg::OPC_VOXEL, pick_voxel(density));
        end
        drains = int'(sb.unanswered) + 1;
        repeat (drains) send_item(vsem_pkg::OPC_FLUSH, 8'($urandom));
    endtask

    initial
    begin
        logic [7:0]  seed_vals [10] = '{8'd255, 8'd255, 8'd0, 8'd254, 8'd1,
                                        8'd128, 8'd127, 8'd255, 8'd170, 8'd85};
        int unsigned sx, sy, sz, vol;
        int          n;
        logic [15:0] rx, ry, rz;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes: flush with nothing pending, the value extremes, flushes that
        // reach voxels whose neighbours have not arrived yet
        send_item(vsem_pkg::OPC_FLUSH, 8'hFF);
        foreach (seed_vals[i])
            send_item(vsem_pkg::OPC_VOXEL, seed_vals[i]);
        repeat (3) send_item(vsem_pkg::OPC_FLUSH, 8'h00);
        send_item(vsem_pkg::OPC_VOXEL, 8'd255);
        wait_results(SETTLE);
        // Write to the unused index: no restart, positions carry on
        set_reg(REG_UNUSED, 16'hFFFF);
        send_item(vsem_pkg::OPC_VOXEL, 8'd255);
        send_item(vsem_pkg::OPC_VOXEL, 8'd255);
        n = int'(sb.unanswered) + 1;
        repeat (n) send_item(vsem_pkg::OPC_FLUSH, 8'h5A);

        // Size extremes: zero as one, full row, full column, clamped values,
        // deepest volume; a solid cube gives a guaranteed interior voxel
        run_phase(16'h0000, 16'h0000, 16'h0000, 12, 60, 1'b1, 1'b0);
        run_phase(16'h0003, 16'h0003, 16'h0003, 27, 100, 1'b0, 1'b0);
        run_phase(16'h0003, 16'h0003, 16'h0003, 54, 92, 1'b1, 1'b0);
        run_phase((16'($urandom) << 9) | 16'd256, 16'h0001, 16'h0001, 60, 85, 1'b0, 1'b0);
        run_phase((16'($urandom) << 9) | 16'h01FF, 16'h0002, 16'h0001, 40, 85, 1'b1, 1'b0);
        run_phase(16'h0001, (16'($urandom) << 9) | 16'd256, 16'h0001, 40, 85, 1'b0, 1'b0);
        run_phase(16'h0002, 16'hFFFF, 16'h0001, 30, 85, 1'b1, 1'b0);
        run_phase(16'h0002, 16'h0002, 16'hFFFF, 40, 90, 1'b1, 1'b0);
        run_phase(16'h0004, 16'h0003, 16'h0002, 48, 90, 1'b0, 1'b1);

        // Random small volumes, mostly whole ones back to back
        while (items_sent < ITEM_TARGET)
        begin
            sx  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            sy  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
            sz  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
            vol = (sx == 0 ? 1 : sx) * (sy == 0 ? 1 : sy) * (sz == 0 ? 1 : sz);
            if ($urandom_range(0, 3) == 0)
                n = int'($urandom_range(1, vol));
            else
                n = int'(vol * $urandom_range(1, 3));
            if (n > 160)
                n = 160;
            rx = (16'($urandom) << 9) | 16'(sx);
            ry = (16'($urandom) << 9) | 16'(sy);
            rz = 16'(sz);
            run_phase(rx, ry, rz, n, int'($urandom_range(20, 98)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        end

        wait_results(SETTLE);
        if (sb.edge_expected.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.edge_expected.size());
            sb.faults++;
        end
        if (sb.faults == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
